// File: sv/quiet_window_detector_core_macros.svh
// Assertion macros shared by the quiet window detector RTL.
// Needs no other file; each macro samples on the rising clock edge.
`ifndef QUIET_WINDOW_DETECTOR_CORE_MACROS_SVH
`define QUIET_WINDOW_DETECTOR_CORE_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define QWD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("qwd check failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define QWD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qwd check failed");

// When the antecedent holds, the consequent holds in the cycle after.
`define QWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qwd check failed");

`endif

// File: sv/qwd_pkg.sv
// Shared types and constants of the quiet window detector.
// Used by the result queue and the top level; depends on nothing.
package qwd_pkg;

    localparam int unsigned POS_BITS    = 32;
    localparam int unsigned WLEN_BITS   = 9;
    localparam int unsigned THR_BITS    = 16;
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned QCNT_BITS   = 2;
    localparam int unsigned QPTR_BITS   = 2;

    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_THRESHOLD     = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [POS_BITS-1:0] window_start;
        logic                none_found;
    } t_result;

endpackage

// File: sv/qwd_cell.sv
// One running max/min cell of the systolic chain.
// Standalone; takes its neighbor's previous max/min and the new sample.
module qwd_cell #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_max,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_min,
    output logic signed [SAMPLE_BITS-1:0] o_max,
    output logic signed [SAMPLE_BITS-1:0] o_min
);

    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] n_max;
    logic signed [SAMPLE_BITS-1:0] n_min;

    always_comb begin
        n_max = (i_prev_max > i_sample) ? i_prev_max : i_sample;
        n_min = (i_prev_min < i_sample) ? i_prev_min : i_sample;
    end

    // Contents are only read once the recording has filled this cell.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_max <= n_max;
            r_min <= n_min;
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

// File: sv/qwd_result_queue.sv
// Small result queue between the window evaluation and the output port.
// Depends on qwd_pkg for the result type and the queue depth.
`include "quiet_window_detector_core_macros.svh"

module qwd_result_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  qwd_pkg::t_result                    i_data,
    input  logic                                i_pop,
    output logic [qwd_pkg::QCNT_BITS-1:0]       o_count,
    output qwd_pkg::t_result                    o_data
);

    qwd_pkg::t_result                   r_mem [qwd_pkg::QUEUE_DEPTH];
    logic [qwd_pkg::QPTR_BITS-1:0]      r_wr_ptr;
    logic [qwd_pkg::QPTR_BITS-1:0]      r_rd_ptr;
    logic [qwd_pkg::QCNT_BITS-1:0]      r_count;
    logic [qwd_pkg::QPTR_BITS-1:0]      n_wr_ptr;
    logic [qwd_pkg::QPTR_BITS-1:0]      n_rd_ptr;
    logic                               w_pop;

    localparam logic [qwd_pkg::QPTR_BITS-1:0] LAST_PTR =
        qwd_pkg::QPTR_BITS'(qwd_pkg::QUEUE_DEPTH - 1);

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    // The producer's credit check must keep a full queue from taking more.
    `QWD_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        !(i_push && !w_pop && (r_count == qwd_pkg::QCNT_BITS'(qwd_pkg::QUEUE_DEPTH))))
    `QWD_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= qwd_pkg::QCNT_BITS'(qwd_pkg::QUEUE_DEPTH))

endmodule

// File: sv/quiet_window_detector_core.sv
// Top level of the quiet window detector: cell chain, window test, result queue.
// Depends on qwd_pkg, qwd_cell, qwd_result_queue and the assertion macro header.
//
// Usage: samples enter on the i_valid/o_ready channel, one signed sample per
// transaction, with i_last_sample marking the end of a recording. Results leave
// on the o_valid/i_ready channel: the 1-based start of each quiet window, or a
// single none result at the end of a recording that had no quiet window.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_wdata)
// that the user must write only while the block is idle; the block does not
// enforce it. Index 0 is the window length, 1 the threshold.
// Throughput is one sample per cycle while o_ready is high: every cell of the
// chain updates its running max/min in the same cycle. A result reaches the
// output through registers: the cells and the evaluation stage capture the
// accepted sample, then the selected cell's max-minus-min test writes the
// result into the queue that drives the output.
// Reset clears the sample counter, the found flag and the queue, and sets the
// window length to 1 and the threshold to 0; cell contents are left as they are
// because a cell is only read once the recording has filled it.
// When the receiver stalls, results collect in a three-entry queue, and o_ready
// drops once the queue and the evaluation stage together could not take more.
`include "quiet_window_detector_core_macros.svh"

module quiet_window_detector_core #(
    parameter int unsigned MAX_WINDOW  = 256,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_last_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [qwd_pkg::POS_BITS-1:0]          o_window_start,
    output logic                                  o_none_found,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [qwd_pkg::THR_BITS-1:0]          i_cfg_wdata
);

    localparam int unsigned IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned EXT_BITS =
        (IDX_BITS > qwd_pkg::WLEN_BITS) ? IDX_BITS : qwd_pkg::WLEN_BITS;
    localparam int unsigned CMP_BITS =
        (SAMPLE_BITS > qwd_pkg::THR_BITS) ? SAMPLE_BITS : qwd_pkg::THR_BITS;

    // Configuration, with the window length already clamped to the chain.
    logic [qwd_pkg::WLEN_BITS-1:0]   r_win_len;
    logic [IDX_BITS-1:0]             r_win_idx;
    logic [qwd_pkg::THR_BITS-1:0]    r_threshold;
    logic [qwd_pkg::WLEN_BITS-1:0]   w_cfg_len;
    logic [qwd_pkg::WLEN_BITS-1:0]   w_cfg_len_m1;
    logic [EXT_BITS-1:0]             w_cfg_len_ext;

    // Sample counting and the evaluation stage.
    logic [qwd_pkg::POS_BITS-1:0]    r_seen;
    logic [qwd_pkg::POS_BITS-1:0]    n_seen;
    logic                            r_p_valid;
    logic                            r_p_last;
    logic                            r_p_count_ok;
    logic [qwd_pkg::POS_BITS-1:0]    r_p_start;
    logic                            r_found;
    logic                            w_accept;
    logic [qwd_pkg::POS_BITS-1:0]    w_len_pos;

    // Cell chain taps.
    logic signed [SAMPLE_BITS-1:0]   w_max [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0]   w_min [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0]   w_sel_max;
    logic signed [SAMPLE_BITS-1:0]   w_sel_min;
    logic signed [SAMPLE_BITS:0]     w_diff;
    logic [SAMPLE_BITS-1:0]          w_span;
    logic                            w_quiet;
    logic                            w_res_valid;
    qwd_pkg::t_result                w_res;

    // Result queue.
    logic [qwd_pkg::QCNT_BITS-1:0]   w_q_count;
    qwd_pkg::t_result                w_q_data;
    logic                            w_out_fire;

    assign w_accept   = i_valid && o_ready;
    assign w_out_fire = o_valid && i_ready;

    // Room is needed for the result of the item already in evaluation too.
    assign o_ready = ((qwd_pkg::QCNT_BITS + 1)'(w_q_count) + (qwd_pkg::QCNT_BITS + 1)'(r_p_valid))
                     < (qwd_pkg::QCNT_BITS + 1)'(qwd_pkg::QUEUE_DEPTH);

    always_comb begin
        if (i_cfg_wdata[qwd_pkg::WLEN_BITS-1:0] == '0) begin
            w_cfg_len = qwd_pkg::WLEN_BITS'(1);
        end else if (32'(i_cfg_wdata[qwd_pkg::WLEN_BITS-1:0]) > 32'(MAX_WINDOW)) begin
            w_cfg_len = qwd_pkg::WLEN_BITS'(MAX_WINDOW);
        end else begin
            w_cfg_len = i_cfg_wdata[qwd_pkg::WLEN_BITS-1:0];
        end
        w_cfg_len_m1  = w_cfg_len - 1'b1;
        w_cfg_len_ext = EXT_BITS'(w_cfg_len_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= qwd_pkg::WLEN_BITS'(1);
            r_win_idx   <= '0;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (qwd_pkg::t_cfg_index'(i_cfg_index))
                qwd_pkg::CFG_WINDOW_LENGTH: begin
                    r_win_len <= w_cfg_len;
                    r_win_idx <= w_cfg_len_ext[IDX_BITS-1:0];
                end
                qwd_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Cell 0 takes the sample alone; every other cell merges its neighbor.
    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cells
            if (g == 0) begin : g_head
                qwd_cell #(
                    .SAMPLE_BITS(SAMPLE_BITS)
                ) u_cell (
                    .i_clk      (i_clk),
                    .i_load     (w_accept),
                    .i_sample   (i_sample),
                    .i_prev_max (i_sample),
                    .i_prev_min (i_sample),
                    .o_max      (w_max[g]),
                    .o_min      (w_min[g])
                );
            end else begin : g_body
                qwd_cell #(
                    .SAMPLE_BITS(SAMPLE_BITS)
                ) u_cell (
                    .i_clk      (i_clk),
                    .i_load     (w_accept),
                    .i_sample   (i_sample),
                    .i_prev_max (w_max[g-1]),
                    .i_prev_min (w_min[g-1]),
                    .o_max      (w_max[g]),
                    .o_min      (w_min[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_seen    = (r_seen == '1) ? r_seen : r_seen + 1'b1;
        w_len_pos = qwd_pkg::POS_BITS'(r_win_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_accept;
            if (w_accept) begin
                r_seen <= i_last_sample ? '0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_last     <= i_last_sample;
            r_p_count_ok <= (n_seen >= w_len_pos);
            r_p_start    <= n_seen - w_len_pos + 1'b1;
        end
    end

    // Window test on the cell that covers exactly the configured length.
    always_comb begin
        w_sel_max   = w_max[r_win_idx];
        w_sel_min   = w_min[r_win_idx];
        w_diff      = {w_sel_max[SAMPLE_BITS-1], w_sel_max}
                    - {w_sel_min[SAMPLE_BITS-1], w_sel_min};
        w_span      = w_diff[SAMPLE_BITS-1:0];
        w_quiet     = r_p_count_ok && (CMP_BITS'(w_span) <= CMP_BITS'(r_threshold));
        w_res_valid = r_p_valid && (w_quiet || (r_p_last && !r_found));
        w_res.window_start = w_quiet ? r_p_start : '0;
        w_res.none_found   = !w_quiet;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (r_p_valid) begin
            r_found <= r_p_last ? 1'b0 : (r_found || w_quiet);
        end
    end

    qwd_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (w_out_fire),
        .o_count (w_q_count),
        .o_data  (w_q_data)
    );

    assign o_valid        = (w_q_count != '0);
    assign o_window_start = w_q_data.window_start;
    assign o_none_found   = w_q_data.none_found;

    `QWD_ASSERT_NEXT(a_last_clears_count, i_clk, i_rst_n,
        w_accept && i_last_sample, r_seen == '0)
    `QWD_ASSERT_SAME(a_quiet_start_nonzero, i_clk, i_rst_n,
        r_p_valid && w_quiet, r_p_start != '0)
    `QWD_ASSERT_SAME(a_none_only_once, i_clk, i_rst_n,
        w_res_valid && w_res.none_found, r_p_last && !r_found)

endmodule

// File: bench/quiet_window_checker.sv
// Checker for the quiet window detector: predicts quiet-window and none results per sample.
// Watches the sample, result and configuration channels; depends on qwd_pkg.
module quiet_window_checker
    import qwd_pkg::*;
#(
    parameter int unsigned MAX_WINDOW  = 256,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic                          i_in_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [POS_BITS-1:0]           i_out_start,
    input  logic                          i_out_none,
    input  logic                          i_cfg_we,
    input  t_cfg_index                    i_cfg_index,
    input  logic [THR_BITS-1:0]           i_cfg_wdata,
    output int                            o_pending,
    output int                            o_fail_count
);

    logic signed [SAMPLE_BITS-1:0] max_chain [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] min_chain [MAX_WINDOW];
    logic [POS_BITS-1:0]           seen_count;
    logic                          quiet_seen;
    logic [WLEN_BITS-1:0]          win_len;
    logic [THR_BITS-1:0]           thr_reg;
    t_result                       pending_reports [$];

    task automatic report_mismatch(input string what);
        if (o_fail_count < 20) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        o_fail_count++;
    endtask

    function void clear_recording();
        int k;
        for (k = 0; k < MAX_WINDOW; k++) begin
            max_chain[k] = '0;
            min_chain[k] = '0;
        end
        seen_count = '0;
        quiet_seen = 1'b0;
    endfunction

    // Shifts one sample into the running max/min chain and tests the window
    // that ends at it. Returns 1 when the sample produces a result.
    function bit take_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic is_last,
                             output t_result res);
        int k;
        int eff;
        int span;
        bit hit;
        eff = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
        for (k = MAX_WINDOW - 1; k > 0; k--) begin
            max_chain[k] = (max_chain[k-1] > smp) ? max_chain[k-1] : smp;
            min_chain[k] = (min_chain[k-1] < smp) ? min_chain[k-1] : smp;
        end
        max_chain[0] = smp;
        min_chain[0] = smp;
        if (seen_count != '1) begin
            seen_count++;
        end
        hit = 1'b0;
        res = '0;
        if (seen_count >= eff) begin
            span = int'(max_chain[eff-1]) - int'(min_chain[eff-1]);
            if (span <= int'(thr_reg)) begin
                res.window_start = seen_count - eff + 1;
                res.none_found   = 1'b0;
                quiet_seen       = 1'b1;
                hit              = 1'b1;
            end
        end
        if (is_last) begin
            // A quiet window anywhere in the recording, also on the final sample, suppresses the none result.
            if (!quiet_seen) begin
                res.window_start = '0;
                res.none_found   = 1'b1;
                hit              = 1'b1;
            end
            clear_recording();
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_result fresh;
        t_result oldest;
        if (!i_rst_n) begin
            clear_recording();
            win_len = 1;
            thr_reg = '0;
            pending_reports.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (take_sample(i_in_sample, i_in_last, fresh)) begin
                    pending_reports.push_back(fresh);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected result start %0d none %0b",
                                              i_out_start, i_out_none));
                end else begin
                    oldest = pending_reports.pop_front();
                    if (i_out_start !== oldest.window_start) begin
                        report_mismatch($sformatf("window_start %0d, expected %0d",
                                                  i_out_start, oldest.window_start));
                    end
                    if (i_out_none !== oldest.none_found) begin
                        report_mismatch($sformatf("none_found %0b, expected %0b",
                                                  i_out_none, oldest.none_found));
                    end
                end
            end
            // A register write applies from the next sample on.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LENGTH: win_len = i_cfg_wdata[WLEN_BITS-1:0];
                    CFG_THRESHOLD:     thr_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending <= pending_reports.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the quiet window detector bench: clock, reset, sample and result traffic.
// Depends on qwd_pkg, quiet_window_detector_core and quiet_window_checker.
module testbench;
    import qwd_pkg::*;

    localparam int WINDOW_CELLS = 256;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic signed [15:0]     in_sample = '0;
    logic                   in_last   = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [POS_BITS-1:0]    out_start;
    logic                   out_none;
    logic                   cfg_we    = 1'b0;
    t_cfg_index             cfg_index = CFG_WINDOW_LENGTH;
    logic [THR_BITS-1:0]    cfg_wdata = '0;
    int                     pending;
    int                     fail_count;
    int                     cycles    = 0;
    bit                     no_gaps   = 1'b0;

    quiet_window_detector_core #(
        .MAX_WINDOW (WINDOW_CELLS),
        .SAMPLE_BITS(16)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_sample      (in_sample),
        .i_last_sample (in_last),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_window_start(out_start),
        .o_none_found  (out_none),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    quiet_window_checker #(
        .MAX_WINDOW (WINDOW_CELLS),
        .SAMPLE_BITS(16)
    ) window_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_sample (in_sample),
        .i_in_last   (in_last),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_start (out_start),
        .i_out_none  (out_none),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offers one sample and returns at the edge where the transaction completes.
    // Valid is only dropped when a gap precedes the item.
    task automatic send_item(input logic signed [15:0] smp, input logic is_last);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 98) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        in_last   <= is_last;
        do @(posedge clk); while (!in_ready);
    endtask

    // Waits until every predicted result has been taken, then lets the
    // pipeline settle so that samples without results are done as well.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [THR_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int wlen, input int thr);
        cfg_write(CFG_WINDOW_LENGTH, THR_BITS'(wlen));
        cfg_write(CFG_THRESHOLD, THR_BITS'(thr));
    endtask

    // Result side: one long hold at the start so the block backs up, then
    // random ready runs with mostly short stalls.
    initial begin : result_side
        int run;
        int hold;
        int r;
        repeat (10) @(posedge clk);
        repeat (300) @(posedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 15);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 19);
            if (r == 0) begin
                hold = $urandom_range(20, 40);
            end else if (r < 14) begin
                hold = $urandom_range(1, 3);
            end else begin
                hold = 0;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int p;
        int n;
        int w;
        int t;
        int eff;
        int rec_left;
        int style;
        int dev;
        int base;
        int val;
        rec_left = 0;
        w = 1;
        t = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, one-sample window with zero threshold: every sample is quiet.
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        drain(4);

        set_config(4, 10);
        // Recording shorter than the window ends in a none result.
        send_item(16'sd100, 1'b0);
        send_item(16'sd105, 1'b1);
        // The only quiet window ends on the last sample.
        send_item(16'sd1000, 1'b0);
        send_item(-16'sd1000, 1'b0);
        send_item(16'sd3, 1'b0);
        send_item(16'sd5, 1'b0);
        send_item(16'sd7, 1'b0);
        send_item(16'sd9, 1'b1);
        // Full-scale swings never qualify.
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b1);
        drain(4);

        // Zero length acts as one sample; with the widest threshold both full-scale samples are quiet.
        set_config(0, 65535);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b1);
        drain(4);

        // Window length changes in the middle of a recording.
        set_config(2, 0);
        send_item(16'sd7, 1'b0);
        send_item(16'sd7, 1'b0);
        drain(4);
        set_config(3, 0);
        send_item(16'sd7, 1'b0);
        send_item(16'sd9, 1'b1);
        drain(4);

        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin w = 1;   t = 0;     n = 150; end
                1: begin w = 4;   t = 16;    n = 250; end
                2: begin w = 16;  t = 300;   n = 250; end
                3: begin w = 256; t = 65535; n = 300; end
                4: begin w = 0;   t = 5;     n = 150; end
                5: begin
                    w = $urandom_range(2, 40);
                    t = $urandom_range(0, 2000);
                    n = 250;
                end
                6: begin w = 511; t = 20000; n = 250; end
                default: begin
                    w = $urandom_range(1, 300);
                    t = $urandom_range(0, 65535);
                    n = 200;
                end
            endcase
            no_gaps = (p == 0 || p == 4);
            // Recordings may straddle the phase boundary on purpose.
            drain(4);
            set_config(w, t);
            eff = (w == 0) ? 1 : ((w > WINDOW_CELLS) ? WINDOW_CELLS : w);
            repeat (n) begin
                if (rec_left == 0) begin
                    if (eff > 1 && $urandom_range(0, 7) == 0) begin
                        rec_left = $urandom_range(1, eff - 1);
                    end else if (eff >= 64) begin
                        rec_left = $urandom_range(eff, eff + 60);
                    end else begin
                        rec_left = $urandom_range(1, 3 * eff + 10);
                    end
                    style = $urandom_range(0, 9);
                    dev = $urandom_range(0, t + t / 2 + 2);
                    if (dev > 65535) begin
                        dev = 65535;
                    end
                    base = int'($urandom_range(0, 65535)) - 32768 - dev / 2;
                end
                // Mostly a quiet level with jitter near the threshold; some
                // recordings carry spikes and some are plain noise.
                if (style == 0 || (style < 3 && $urandom_range(0, 19) == 0)) begin
                    val = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    val = base + int'($urandom_range(0, dev));
                end
                if (val > 32767) begin
                    val = 32767;
                end else if (val < -32768) begin
                    val = -32768;
                end
                send_item(16'(val), rec_left == 1);
                rec_left--;
            end
        end

        drain(10);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
